### hw/rtl/rqfi_pkg.sv
// ----------------------------------------------------------------------------
// rqfi_pkg
// Shared types and constants for the ring queue with front insert.
// ----------------------------------------------------------------------------
package rqfi_pkg;

  localparam int MAX_SLOTS_DEF = 64;
  localparam int DATA_W        = 64;
  localparam int CFG_W         = 7;
  localparam int CNT_OUT_W     = 6;
  localparam int IN_TDATA_W    = 72;
  localparam int OUT_FIELDS_W  = 1 + DATA_W + CNT_OUT_W + 1 + 1;
  localparam int OUT_TDATA_W   = 80;
  localparam int OUT_PAD_W     = OUT_TDATA_W - OUT_FIELDS_W;
  localparam int CFG_TDATA_W   = 8;

  localparam logic [CFG_W-1:0] LEN_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_PUSH_TAIL = 2'd0,
    OP_PUSH_HEAD = 2'd1,
    OP_POP       = 2'd2,
    OP_PEEK      = 2'd3
  } op_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load_cfg;
    logic exec;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic rd_hit;
    logic out_busy;
  } sts_t;

endpackage

### hw/rtl/ring_queue_with_front_insert_core.sv
// ----------------------------------------------------------------------------
// ring_queue_with_front_insert_core
// Circular 64-bit word queue with push at tail or head, pop and peek.
//
//  channel | dir | payload                               | width
//  --------+-----+---------------------------------------+------
//  in_     | in  | opcode, push_value                    | 72
//  out_    | out | accepted, head_value, count, flags    | 80
//  cfg_    | in  | queue_length                          | 8
//
// Push and refused requests load the result register directly; accepted pop or
// peek first wait in ST_READ for the registered read port of the slot RAM.
// A request is taken only when the result register is free or being drained.
// Synchronous reset: empty queue, ring length 64 (capped to MAX_SLOTS).
// A length write empties the queue; slot contents are kept.
// ----------------------------------------------------------------------------
module ring_queue_with_front_insert_core #(
  parameter int MAX_SLOTS = rqfi_pkg::MAX_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // [1:0] opcode, [65:2] push_value
  input  logic [rqfi_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [0] accepted, [64:1] head_value, [70:65] entry_count, [71] is_full,
  // [72] is_empty
  output logic [rqfi_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [6:0] queue_length
  input  logic [rqfi_pkg::CFG_TDATA_W-1:0] cfg_tdata,
  input  logic                             cfg_tvalid,
  output logic                             cfg_tready
);
  import rqfi_pkg::*;

  cmd_t cmd;
  sts_t sts;

  logic                 accepted;
  logic [DATA_W-1:0]    head_value;
  logic [CNT_OUT_W-1:0] entry_count;
  logic                 is_full;
  logic                 is_empty;

  rqfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rqfi_dp #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .opcode      (op_t'(in_tdata[1:0])),
    .push_value  (in_tdata[DATA_W+1:2]),
    .queue_length(cfg_tdata[CFG_W-1:0]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .accepted    (accepted),
    .head_value  (head_value),
    .entry_count (entry_count),
    .is_full     (is_full),
    .is_empty    (is_empty)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, is_empty, is_full, entry_count,
                      head_value, accepted};

  a_no_take_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !(out_tvalid && !out_tready))
    else $error("request taken while result stalled");

  a_cfg_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_tvalid && cfg_tready && in_tvalid && in_tready))
    else $error("config write and request in one cycle");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && sts.rd_hit) |-> ##2 out_tvalid)
    else $error("pop/peek result missing");

  a_fast_result: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && !sts.rd_hit) |=> out_tvalid)
    else $error("push/refused result missing");

endmodule

### hw/rtl/rqfi_ram.sv
// ----------------------------------------------------------------------------
// rqfi_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rqfi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  parameter int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rqfi_ctrl.sv
// ----------------------------------------------------------------------------
// rqfi_ctrl
// Sequencer: handshakes and the wait for registered slot read data.
// ----------------------------------------------------------------------------
module rqfi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic          cfg_tvalid,
  output logic          cfg_tready,
  input  rqfi_pkg::sts_t sts,
  output rqfi_pkg::cmd_t cmd
);
  import rqfi_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cfg_tready   = 1'b0;
    in_tready    = 1'b0;
    cmd.load_cfg = 1'b0;
    cmd.exec     = 1'b0;
    cmd.finish   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        cfg_tready   = 1'b1;
        in_tready    = !sts.out_busy && !cfg_tvalid;
        cmd.load_cfg = cfg_tvalid;
        cmd.exec     = in_tvalid && in_tready;
        if (cmd.exec && sts.rd_hit) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### hw/rtl/rqfi_dp.sv
// ----------------------------------------------------------------------------
// rqfi_dp
// Datapath: ring pointers, count, slot RAM and result register.
// ----------------------------------------------------------------------------
module rqfi_dp #(
  parameter int MAX_SLOTS = rqfi_pkg::MAX_SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rqfi_pkg::cmd_t                 cmd,
  output rqfi_pkg::sts_t                 sts,
  input  rqfi_pkg::op_t                  opcode,
  input  logic [rqfi_pkg::DATA_W-1:0]    push_value,
  input  logic [rqfi_pkg::CFG_W-1:0]     queue_length,
  input  logic                           out_tready,
  output logic                           out_tvalid,
  output logic                           accepted,
  output logic [rqfi_pkg::DATA_W-1:0]    head_value,
  output logic [rqfi_pkg::CNT_OUT_W-1:0] entry_count,
  output logic                           is_full,
  output logic                           is_empty
);
  import rqfi_pkg::*;

  localparam int IDX_W = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
  localparam int LEN_W = $clog2(MAX_SLOTS + 1);
  localparam int CMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
  localparam int EXT_W = (IDX_W > CNT_OUT_W) ? IDX_W : CNT_OUT_W;

  function automatic logic [LEN_W-1:0] clamp_len(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w < CMP_W'(2)) begin
      return LEN_W'(2);
    end else if (w > CMP_W'(MAX_SLOTS)) begin
      return LEN_W'(MAX_SLOTS);
    end
    return LEN_W'(w);
  endfunction

  function automatic logic [IDX_W-1:0] step_fwd(input logic [IDX_W-1:0] i,
                                                input logic [LEN_W-1:0] n);
    logic [LEN_W-1:0] s;
    s = LEN_W'(i) + LEN_W'(1);
    return (s >= n) ? '0 : IDX_W'(s);
  endfunction

  function automatic logic [IDX_W-1:0] step_back(input logic [IDX_W-1:0] i,
                                                 input logic [LEN_W-1:0] n);
    if (i == '0 || LEN_W'(i) >= n) begin
      return IDX_W'(n - LEN_W'(1));
    end
    return i - IDX_W'(1);
  endfunction

  logic [LEN_W-1:0] len_r;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [IDX_W-1:0] cnt_r, cnt_nxt;

  logic             out_valid_r;
  logic             acc_r, acc_nxt;
  logic [DATA_W-1:0] head_val_r;
  logic [EXT_W-1:0] cnt_out_r;
  logic             full_r, empty_r;

  logic             is_push, can_push, has_data;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr;
  logic [DATA_W-1:0] ram_rdata;
  logic [LEN_W-1:0] cnt_nxt_p1;

  assign is_push  = (opcode == OP_PUSH_TAIL) || (opcode == OP_PUSH_HEAD);
  assign can_push = (LEN_W'(cnt_r) + LEN_W'(1)) < len_r;
  assign has_data = (cnt_r != '0);

  assign sts.rd_hit   = !is_push && has_data;
  assign sts.out_busy = out_valid_r && !out_tready;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = tail_r;
    if (cmd.exec) begin
      case (opcode)
        OP_PUSH_TAIL: begin
          if (can_push) begin
            ram_we   = 1'b1;
            tail_nxt = step_fwd(tail_r, len_r);
            cnt_nxt  = cnt_r + IDX_W'(1);
            acc_nxt  = 1'b1;
          end
        end
        OP_PUSH_HEAD: begin
          if (can_push) begin
            ram_we    = 1'b1;
            head_nxt  = step_back(head_r, len_r);
            ram_waddr = head_nxt;
            cnt_nxt   = cnt_r + IDX_W'(1);
            acc_nxt   = 1'b1;
          end
        end
        OP_POP: begin
          if (has_data) begin
            ram_re   = 1'b1;
            head_nxt = step_fwd(head_r, len_r);
            cnt_nxt  = cnt_r - IDX_W'(1);
            acc_nxt  = 1'b1;
          end
        end
        OP_PEEK: begin
          if (has_data) begin
            ram_re  = 1'b1;
            acc_nxt = 1'b1;
          end
        end
        default: begin
          acc_nxt = 1'b0;
        end
      endcase
    end
  end

  assign cnt_nxt_p1 = LEN_W'(cnt_nxt) + LEN_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= clamp_len(LEN_RESET);
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_cfg) begin
        len_r  <= clamp_len(queue_length);
        head_r <= '0;
        tail_r <= '0;
        cnt_r  <= '0;
      end else begin
        head_r <= head_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
      out_valid_r <= cmd.finish || (cmd.exec && !sts.rd_hit) ||
                     (out_valid_r && !out_tready);
    end
  end

  // result fields; head word is taken from the registered RAM read data in ST_READ
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      acc_r      <= acc_nxt;
      head_val_r <= '0;
      cnt_out_r  <= EXT_W'(cnt_nxt);
      full_r     <= (cnt_nxt_p1 == len_r);
      empty_r    <= (cnt_nxt == '0);
    end else if (cmd.finish) begin
      head_val_r <= ram_rdata;
    end
  end

  rqfi_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_SLOTS),
    .ADDR_W(IDX_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(push_value),
    .re   (ram_re),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  assign out_tvalid  = out_valid_r;
  assign accepted    = acc_r;
  assign head_value  = head_val_r;
  assign entry_count = cnt_out_r[CNT_OUT_W-1:0];
  assign is_full     = full_r;
  assign is_empty    = empty_r;

endmodule
